[src/pmau_pkg.sv]
// shared types and constants for the prime modular arithmetic unit
package pmau_pkg;

    localparam int M_W          = 31;
    localparam int CMD_W        = 3;
    localparam int EXP_W        = 63;
    localparam int RAW_W        = 63;
    localparam int IDX_W        = 6;
    localparam int CNT_W        = 6;
    localparam int EXP_BITS_DEF = 63;

    localparam logic [M_W-1:0] MOD_RESET = 31'd1000000007;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD    = 3'd0,
        CMD_SUB    = 3'd1,
        CMD_MUL    = 3'd2,
        CMD_POW    = 3'd3,
        CMD_INV    = 3'd4,
        CMD_DIV    = 3'd5,
        CMD_REDUCE = 3'd6
    } cmd_t;

    typedef enum logic [4:0] {
        OP_NOP,
        OP_LOAD,
        OP_START_A,
        OP_STEP,
        OP_A_DONE,
        OP_B_DONE,
        OP_ACC_DONE,
        OP_FIN_DONE,
        OP_ADD,
        OP_SUB,
        OP_ZERO,
        OP_ACC_OUT,
        OP_POW_INIT,
        OP_INVA_INIT,
        OP_INVB_INIT,
        OP_MUL_AB,
        OP_MUL_SQ,
        OP_MUL_BASE,
        OP_MUL_A_ACC,
        OP_PUSH
    } dp_op_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_RED_A,
        S_RED_B,
        S_ARITH,
        S_SQ,
        S_SQ_RED,
        S_MUL,
        S_MUL_RED,
        S_FIN_RED,
        S_OUT
    } state_t;

    typedef struct packed {
        logic m_small;
        cmd_t cmd;
        logic a_zero;
        logic b_zero;
        logic red_last;
        logic idx_zero;
        logic ebit;
        logic out_free;
    } dp_status_t;

endpackage

[src/pmau_if.sv]
// request and response channel interfaces of the modular arithmetic unit
interface pmau_req_if;
    logic                       valid;
    logic                       ready;
    logic [pmau_pkg::CMD_W-1:0] cmd;
    logic [pmau_pkg::M_W-1:0]   operand_a;
    logic [pmau_pkg::M_W-1:0]   operand_b;
    logic [pmau_pkg::EXP_W-1:0] exponent;
    logic [pmau_pkg::RAW_W-1:0] raw_value;

    modport source (output valid, cmd, operand_a, operand_b, exponent, raw_value,
                    input ready);
    modport sink (input valid, cmd, operand_a, operand_b, exponent, raw_value,
                  output ready);
endinterface

interface pmau_rsp_if;
    logic                     valid;
    logic                     ready;
    logic [pmau_pkg::M_W-1:0] result;

    modport source (output valid, result, input ready);
    modport sink (input valid, result, output ready);
endinterface

[src/prime_modular_arithmetic_unit.sv]
// top level of the prime modular arithmetic unit
//
// req channel (valid/ready): one item carries cmd, operand_a, operand_b, exponent
// and raw_value; rsp channel (valid/ready) returns one residue per item.
// cfg_we/cfg_wdata write the modulus; write it only while no item is in flight.
// items are worked one at a time on a shared 31x31 multiplier and a remainder
// unit that retires one bit per cycle; the work done depends on the command:
//   add, subtract        two 31-bit operand reductions
//   multiply             operand reductions plus 62-bit product
//   reduce               63-bit raw value
//   power                a square for each of EXP_BITS bits, a multiply for each set bit
//   inverse              a power to m-2 over 31 bits
//   divide               inverse plus one more multiply
//   unused command or modulus below 2: zero
// the unit is ready again in the cycle after the result is parked in the output
// register; a stalled receiver holds the next finished result and with it the input.
// reset sets the modulus to 1000000007 and empties the unit.
module prime_modular_arithmetic_unit #(
    parameter int EXP_BITS = pmau_pkg::EXP_BITS_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [pmau_pkg::M_W-1:0] cfg_wdata,
    pmau_req_if.sink                 req,
    pmau_rsp_if.source               rsp
);

    pmau_pkg::dp_op_t     op;
    pmau_pkg::dp_status_t status;

    pmau_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .status   (status),
        .op       (op)
    );

    pmau_datapath #(
        .EXP_BITS (EXP_BITS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .in_cmd     (req.cmd),
        .in_a       (req.operand_a),
        .in_b       (req.operand_b),
        .in_exp     (req.exponent),
        .in_raw     (req.raw_value),
        .op         (op),
        .status     (status),
        .out_ready  (rsp.ready),
        .out_valid  (rsp.valid),
        .out_result (rsp.result)
    );

endmodule

[src/pmau_datapath.sv]
// datapath: operand registers, shared multiplier, bit-serial remainder unit, output register
module pmau_datapath #(
    parameter int EXP_BITS = pmau_pkg::EXP_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [pmau_pkg::M_W-1:0]   cfg_wdata,
    input  logic [pmau_pkg::CMD_W-1:0] in_cmd,
    input  logic [pmau_pkg::M_W-1:0]   in_a,
    input  logic [pmau_pkg::M_W-1:0]   in_b,
    input  logic [pmau_pkg::EXP_W-1:0] in_exp,
    input  logic [pmau_pkg::RAW_W-1:0] in_raw,
    input  pmau_pkg::dp_op_t           op,
    output pmau_pkg::dp_status_t       status,
    input  logic                       out_ready,
    output logic                       out_valid,
    output logic [pmau_pkg::M_W-1:0]   out_result
);

    localparam int M_W   = pmau_pkg::M_W;
    localparam int RAW_W = pmau_pkg::RAW_W;
    localparam int EXP_W = pmau_pkg::EXP_W;
    localparam int IDX_W = pmau_pkg::IDX_W;
    localparam int CNT_W = pmau_pkg::CNT_W;
    localparam int PAD_W = RAW_W - M_W;

    logic [M_W-1:0]                 modulus_reg;
    logic                           out_valid_reg;
    logic [pmau_pkg::CMD_W-1:0]     cmd_reg;
    logic [M_W-1:0]                 a_reg;
    logic [M_W-1:0]                 b_reg;
    logic [M_W-1:0]                 base_reg;
    logic [M_W-1:0]                 acc_reg;
    logic [M_W-1:0]                 fin_reg;
    logic [M_W-1:0]                 res_reg;
    logic [EXP_W-1:0]               exp_reg;
    logic [IDX_W-1:0]               idx_reg;
    logic [M_W-1:0]                 rem_reg;
    logic [RAW_W-1:0]               shift_reg;
    logic [CNT_W-1:0]               cnt_reg;

    logic [M_W:0]                   m_ext;
    logic [M_W:0]                   trial;
    logic [M_W-1:0]                 rem_next;
    logic [M_W:0]                   sum_add;
    logic [M_W:0]                   sum_sub;
    logic [M_W-1:0]                 add_res;
    logic [M_W-1:0]                 sub_res;
    logic [M_W-1:0]                 mul_x;
    logic [M_W-1:0]                 mul_y;
    logic [2*M_W-1:0]               prod;
    logic [EXP_W:0]                 exp_ext;

    assign m_ext = {1'b0, modulus_reg};

    // one restoring remainder step: bring in the next bit, subtract modulus if it fits
    assign trial    = {rem_reg, shift_reg[RAW_W-1]};
    assign rem_next = (trial >= m_ext) ? M_W'(trial - m_ext) : trial[M_W-1:0];

    assign sum_add = {1'b0, a_reg} + {1'b0, b_reg};
    assign sum_sub = {1'b0, a_reg} + {1'b0, M_W'(modulus_reg - b_reg)};
    assign add_res = (sum_add >= m_ext) ? M_W'(sum_add - m_ext) : sum_add[M_W-1:0];
    assign sub_res = (sum_sub >= m_ext) ? M_W'(sum_sub - m_ext) : sum_sub[M_W-1:0];

    always_comb
    begin
        unique case (op)
            pmau_pkg::OP_MUL_SQ:
            begin
                mul_x = acc_reg;
                mul_y = acc_reg;
            end
            pmau_pkg::OP_MUL_BASE:
            begin
                mul_x = acc_reg;
                mul_y = base_reg;
            end
            pmau_pkg::OP_MUL_A_ACC:
            begin
                mul_x = a_reg;
                mul_y = acc_reg;
            end
            default:
            begin
                mul_x = a_reg;
                mul_y = b_reg;
            end
        endcase
    end

    assign prod = (2*M_W)'(mul_x) * (2*M_W)'(mul_y);

    assign exp_ext = {1'b0, exp_reg};

    assign status.m_small  = (modulus_reg < M_W'(2));
    assign status.cmd      = pmau_pkg::cmd_t'(cmd_reg);
    assign status.a_zero   = (a_reg == '0);
    assign status.b_zero   = (b_reg == '0);
    assign status.red_last = (cnt_reg == CNT_W'(1));
    assign status.idx_zero = (idx_reg == '0);
    assign status.ebit     = exp_ext[idx_reg];
    assign status.out_free = !out_valid_reg || out_ready;

    assign out_valid  = out_valid_reg;
    assign out_result = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg   <= pmau_pkg::MOD_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                modulus_reg <= cfg_wdata;
            end
            if (op == pmau_pkg::OP_PUSH)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (op) inside
            pmau_pkg::OP_LOAD:
            begin
                // raw value goes straight into the remainder unit for reduce
                cmd_reg   <= in_cmd;
                a_reg     <= in_a;
                b_reg     <= in_b;
                exp_reg   <= in_exp;
                shift_reg <= in_raw;
                cnt_reg   <= CNT_W'(RAW_W);
                rem_reg   <= '0;
            end
            pmau_pkg::OP_START_A:
            begin
                shift_reg <= {a_reg, {PAD_W{1'b0}}};
                cnt_reg   <= CNT_W'(M_W);
                rem_reg   <= '0;
            end
            pmau_pkg::OP_STEP:
            begin
                rem_reg   <= rem_next;
                shift_reg <= {shift_reg[RAW_W-2:0], 1'b0};
                cnt_reg   <= cnt_reg - CNT_W'(1);
            end
            pmau_pkg::OP_A_DONE:
            begin
                a_reg     <= rem_next;
                shift_reg <= {b_reg, {PAD_W{1'b0}}};
                cnt_reg   <= CNT_W'(M_W);
                rem_reg   <= '0;
            end
            pmau_pkg::OP_B_DONE:
            begin
                b_reg <= rem_next;
            end
            pmau_pkg::OP_ACC_DONE:
            begin
                acc_reg <= rem_next;
            end
            pmau_pkg::OP_FIN_DONE:
            begin
                fin_reg <= rem_next;
            end
            pmau_pkg::OP_ADD:
            begin
                fin_reg <= add_res;
            end
            pmau_pkg::OP_SUB:
            begin
                fin_reg <= sub_res;
            end
            pmau_pkg::OP_ZERO:
            begin
                fin_reg <= '0;
            end
            pmau_pkg::OP_ACC_OUT:
            begin
                fin_reg <= acc_reg;
            end
            pmau_pkg::OP_POW_INIT:
            begin
                base_reg <= a_reg;
                idx_reg  <= IDX_W'(EXP_BITS);
                acc_reg  <= M_W'(1);
            end
            pmau_pkg::OP_INVA_INIT:
            begin
                // fermat exponent m-2 over the full modulus width
                base_reg <= a_reg;
                exp_reg  <= EXP_W'(M_W'(modulus_reg - M_W'(2)));
                idx_reg  <= IDX_W'(M_W);
                acc_reg  <= M_W'(1);
            end
            pmau_pkg::OP_INVB_INIT:
            begin
                base_reg <= b_reg;
                exp_reg  <= EXP_W'(M_W'(modulus_reg - M_W'(2)));
                idx_reg  <= IDX_W'(M_W);
                acc_reg  <= M_W'(1);
            end
            pmau_pkg::OP_MUL_AB,
            pmau_pkg::OP_MUL_BASE,
            pmau_pkg::OP_MUL_A_ACC:
            begin
                shift_reg <= {prod, 1'b0};
                cnt_reg   <= CNT_W'(2*M_W);
                rem_reg   <= '0;
            end
            pmau_pkg::OP_MUL_SQ:
            begin
                shift_reg <= {prod, 1'b0};
                cnt_reg   <= CNT_W'(2*M_W);
                rem_reg   <= '0;
                idx_reg   <= idx_reg - IDX_W'(1);
            end
            pmau_pkg::OP_PUSH:
            begin
                res_reg <= fin_reg;
            end
            default:
            begin
            end
        endcase
    end

endmodule

[src/pmau_ctrl.sv]
// controller state machine sequencing reductions, multiplies and square-and-multiply
module pmau_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  pmau_pkg::dp_status_t status,
    output pmau_pkg::dp_op_t     op
);

    pmau_pkg::state_t state_reg;
    pmau_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pmau_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        op         = pmau_pkg::OP_NOP;
        in_ready   = 1'b0;
        unique case (state_reg)
            pmau_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    op         = pmau_pkg::OP_LOAD;
                    state_next = pmau_pkg::S_DISPATCH;
                end
            end
            pmau_pkg::S_DISPATCH:
            begin
                if (status.m_small)
                begin
                    op         = pmau_pkg::OP_ZERO;
                    state_next = pmau_pkg::S_OUT;
                end
                else
                begin
                    case (status.cmd) inside
                        pmau_pkg::CMD_ADD, pmau_pkg::CMD_SUB, pmau_pkg::CMD_MUL,
                        pmau_pkg::CMD_POW, pmau_pkg::CMD_INV, pmau_pkg::CMD_DIV:
                        begin
                            op         = pmau_pkg::OP_START_A;
                            state_next = pmau_pkg::S_RED_A;
                        end
                        pmau_pkg::CMD_REDUCE:
                        begin
                            // raw value is already loaded in the remainder unit
                            state_next = pmau_pkg::S_FIN_RED;
                        end
                        default:
                        begin
                            op         = pmau_pkg::OP_ZERO;
                            state_next = pmau_pkg::S_OUT;
                        end
                    endcase
                end
            end
            pmau_pkg::S_RED_A:
            begin
                if (status.red_last)
                begin
                    op         = pmau_pkg::OP_A_DONE;
                    state_next = pmau_pkg::S_RED_B;
                end
                else
                begin
                    op = pmau_pkg::OP_STEP;
                end
            end
            pmau_pkg::S_RED_B:
            begin
                if (status.red_last)
                begin
                    op         = pmau_pkg::OP_B_DONE;
                    state_next = pmau_pkg::S_ARITH;
                end
                else
                begin
                    op = pmau_pkg::OP_STEP;
                end
            end
            pmau_pkg::S_ARITH:
            begin
                case (status.cmd)
                    pmau_pkg::CMD_ADD:
                    begin
                        op         = pmau_pkg::OP_ADD;
                        state_next = pmau_pkg::S_OUT;
                    end
                    pmau_pkg::CMD_SUB:
                    begin
                        op         = pmau_pkg::OP_SUB;
                        state_next = pmau_pkg::S_OUT;
                    end
                    pmau_pkg::CMD_MUL:
                    begin
                        op         = pmau_pkg::OP_MUL_AB;
                        state_next = pmau_pkg::S_FIN_RED;
                    end
                    pmau_pkg::CMD_POW:
                    begin
                        op         = pmau_pkg::OP_POW_INIT;
                        state_next = pmau_pkg::S_SQ;
                    end
                    pmau_pkg::CMD_INV:
                    begin
                        // inverse of zero is zero
                        op         = status.a_zero ? pmau_pkg::OP_ZERO
                                                   : pmau_pkg::OP_INVA_INIT;
                        state_next = status.a_zero ? pmau_pkg::S_OUT : pmau_pkg::S_SQ;
                    end
                    pmau_pkg::CMD_DIV:
                    begin
                        op         = status.b_zero ? pmau_pkg::OP_ZERO
                                                   : pmau_pkg::OP_INVB_INIT;
                        state_next = status.b_zero ? pmau_pkg::S_OUT : pmau_pkg::S_SQ;
                    end
                    default:
                    begin
                        op         = pmau_pkg::OP_ZERO;
                        state_next = pmau_pkg::S_OUT;
                    end
                endcase
            end
            pmau_pkg::S_SQ:
            begin
                if (status.idx_zero)
                begin
                    if (status.cmd == pmau_pkg::CMD_DIV)
                    begin
                        op         = pmau_pkg::OP_MUL_A_ACC;
                        state_next = pmau_pkg::S_FIN_RED;
                    end
                    else
                    begin
                        op         = pmau_pkg::OP_ACC_OUT;
                        state_next = pmau_pkg::S_OUT;
                    end
                end
                else
                begin
                    op         = pmau_pkg::OP_MUL_SQ;
                    state_next = pmau_pkg::S_SQ_RED;
                end
            end
            pmau_pkg::S_SQ_RED:
            begin
                if (status.red_last)
                begin
                    op         = pmau_pkg::OP_ACC_DONE;
                    state_next = status.ebit ? pmau_pkg::S_MUL : pmau_pkg::S_SQ;
                end
                else
                begin
                    op = pmau_pkg::OP_STEP;
                end
            end
            pmau_pkg::S_MUL:
            begin
                op         = pmau_pkg::OP_MUL_BASE;
                state_next = pmau_pkg::S_MUL_RED;
            end
            pmau_pkg::S_MUL_RED:
            begin
                if (status.red_last)
                begin
                    op         = pmau_pkg::OP_ACC_DONE;
                    state_next = pmau_pkg::S_SQ;
                end
                else
                begin
                    op = pmau_pkg::OP_STEP;
                end
            end
            pmau_pkg::S_FIN_RED:
            begin
                if (status.red_last)
                begin
                    op         = pmau_pkg::OP_FIN_DONE;
                    state_next = pmau_pkg::S_OUT;
                end
                else
                begin
                    op = pmau_pkg::OP_STEP;
                end
            end
            pmau_pkg::S_OUT:
            begin
                if (status.out_free)
                begin
                    op         = pmau_pkg::OP_PUSH;
                    state_next = pmau_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = pmau_pkg::S_IDLE;
            end
        endcase
    end

endmodule

[bench/tb_prime_modular_arithmetic_unit.sv]
// testbench for prime_modular_arithmetic_unit: random and directed items checked against a predictor
`timescale 1ns / 100ps

module tb_prime_modular_arithmetic_unit;

    localparam int               M_W         = pmau_pkg::M_W;
    localparam int               CMD_W       = pmau_pkg::CMD_W;
    localparam int               EXP_W       = pmau_pkg::EXP_W;
    localparam int               RAW_W       = pmau_pkg::RAW_W;
    localparam int               EXP_BITS_TB = pmau_pkg::EXP_BITS_DEF;
    localparam logic [CMD_W-1:0] CMD_UNUSED  = 3'd7;
    localparam bit [63:0]        ALL_EXP     = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam bit [63:0]        OPERAND_MAX = 64'd2147483646;
    localparam int               IDLE_PCT    = 9;
    localparam int               STEADY_LO   = 500;
    localparam int               STEADY_HI   = 800;
    localparam int               HOLD_AT     = 150;
    localparam int               HOLD_CYCLES = 20000;
    // every item a full-exponent power plus stalls, three times over
    localparam int               CYCLE_LIMIT = 1800 * 9000 * 3;

    typedef struct {
        bit [CMD_W-1:0] cmd;
        bit [M_W-1:0]   operand_a;
        bit [M_W-1:0]   operand_b;
        bit [EXP_W-1:0] exponent;
        bit [RAW_W-1:0] raw_value;
    } op_item_t;

    logic         clk = 1'b0;
    logic         rst_n;
    logic         cfg_we;
    logic [M_W-1:0] cfg_wdata;

    pmau_req_if req ();
    pmau_rsp_if rsp ();

    prime_modular_arithmetic_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req),
        .rsp       (rsp)
    );

    op_item_t     op_queue[$];
    bit [M_W-1:0] residue_queue[$];
    op_item_t     offered;
    bit [M_W-1:0] modulus_now;
    int           items_sent;
    int           results_seen;
    int           hold_left;
    bit           hold_taken;
    int           mismatches;
    int           cycles;

    always #6 clk = ~clk;

    function automatic bit [63:0] mod_mul(bit [63:0] x, bit [63:0] y, bit [63:0] m);
        return (x * y) % m;
    endfunction

    // square-and-multiply from the top of nbits down
    function automatic bit [63:0] mod_pow(bit [63:0] base, bit [63:0] e, int nbits,
                                          bit [63:0] m);
        bit [63:0] acc;
        acc = 64'd1 % m;
        for (int i = nbits - 1; i >= 0; i--)
        begin
            acc = mod_mul(acc, acc, m);
            if (e[i])
                acc = mod_mul(acc, base, m);
        end
        return acc;
    endfunction

    function automatic bit [63:0] mod_inverse(bit [63:0] x, bit [63:0] m);
        if (x == 0)
            return 64'd0;
        return mod_pow(x, m - 64'd2, 31, m);
    endfunction

    function automatic bit [M_W-1:0] modular_result(op_item_t it, bit [M_W-1:0] mod_value);
        bit [63:0] m;
        bit [63:0] a;
        bit [63:0] b;
        bit [63:0] r;
        m = {33'd0, mod_value};
        if (m < 64'd2)
            return '0;
        a = {33'd0, it.operand_a} % m;
        b = {33'd0, it.operand_b} % m;
        case (it.cmd)
            pmau_pkg::CMD_ADD:
            begin
                r = a + b;
                if (r >= m)
                    r = r - m;
            end
            pmau_pkg::CMD_SUB:
            begin
                r = a + (m - b);
                if (r >= m)
                    r = r - m;
            end
            pmau_pkg::CMD_MUL:    r = mod_mul(a, b, m);
            pmau_pkg::CMD_POW:    r = mod_pow(a, {1'b0, it.exponent}, EXP_BITS_TB, m);
            pmau_pkg::CMD_INV:    r = mod_inverse(a, m);
            pmau_pkg::CMD_DIV:    r = mod_mul(a, mod_inverse(b, m), m);
            pmau_pkg::CMD_REDUCE: r = {1'b0, it.raw_value} % m;
            default:              r = 64'd0;
        endcase
        return r[M_W-1:0];
    endfunction

    function automatic bit [M_W-1:0] pick_operand(bit [M_W-1:0] m);
        int unsigned sel;
        sel = $urandom_range(0, 9);
        if (sel == 0)
            return '0;
        if (sel == 1)
            return (m != 0) ? m - 1'b1 : '0;
        if (sel <= 3 || m < 2)
            return M_W'($urandom_range(0, 32'(OPERAND_MAX)));
        return M_W'($urandom_range(0, {1'b0, m} - 32'd1));
    endfunction

    // power, inverse and divide are slow, so they stay rare
    function automatic op_item_t random_op(bit [M_W-1:0] m);
        op_item_t    it;
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 22)
            it.cmd = pmau_pkg::CMD_ADD;
        else if (sel < 44)
            it.cmd = pmau_pkg::CMD_SUB;
        else if (sel < 64)
            it.cmd = pmau_pkg::CMD_MUL;
        else if (sel < 89)
            it.cmd = pmau_pkg::CMD_REDUCE;
        else if (sel < 92)
            it.cmd = pmau_pkg::CMD_POW;
        else if (sel < 95)
            it.cmd = pmau_pkg::CMD_INV;
        else if (sel < 98)
            it.cmd = pmau_pkg::CMD_DIV;
        else
            it.cmd = CMD_UNUSED;
        it.operand_a = pick_operand(m);
        it.operand_b = pick_operand(m);
        if ($urandom_range(0, 1) == 0)
            it.exponent = EXP_W'($urandom_range(0, 40));
        else
            it.exponent = EXP_W'({$urandom, $urandom} & ALL_EXP);
        if ($urandom_range(0, 2) == 0)
            it.raw_value = RAW_W'({32'd0, $urandom});
        else
            it.raw_value = RAW_W'({$urandom, $urandom} & ALL_EXP);
        return it;
    endfunction

    task automatic push_op(bit [CMD_W-1:0] cmd, bit [63:0] a, bit [63:0] b,
                           bit [63:0] e, bit [63:0] raw);
        op_item_t it;
        it.cmd       = cmd;
        it.operand_a = a[M_W-1:0];
        it.operand_b = b[M_W-1:0];
        it.exponent  = e[EXP_W-1:0];
        it.raw_value = raw[RAW_W-1:0];
        op_queue.insert(op_queue.size(), it);
    endtask

    task automatic wait_drained();
        while (op_queue.size() != 0 || residue_queue.size() != 0 || req.valid)
            @(posedge clk);
    endtask

    task automatic write_modulus(bit [M_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we      <= 1'b0;
        modulus_now = value;
    endtask

    task automatic run_random(int count);
        for (int i = 0; i < count; i++)
            op_queue.insert(op_queue.size(), random_op(modulus_now));
        wait_drained();
    endtask

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req.valid     <= 1'b0;
            req.cmd       <= '0;
            req.operand_a <= '0;
            req.operand_b <= '0;
            req.exponent  <= '0;
            req.raw_value <= '0;
        end
        else if (!req.valid || req.ready)
        begin
            if (req.valid)
                residue_queue.insert(residue_queue.size(),
                                     modular_result(offered, modulus_now));
            if (op_queue.size() != 0 &&
                ((items_sent >= STEADY_LO && items_sent < STEADY_HI) ||
                 $urandom_range(0, 99) >= IDLE_PCT))
            begin
                offered = op_queue.pop_front();
                items_sent++;
                req.valid     <= 1'b1;
                req.cmd       <= offered.cmd;
                req.operand_a <= offered.operand_a;
                req.operand_b <= offered.operand_b;
                req.exponent  <= offered.exponent;
                req.raw_value <= offered.raw_value;
            end
            else
                req.valid <= 1'b0;
        end
    end

    // result checker
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp.ready    <= 1'b0;
            results_seen <= 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                results_seen <= results_seen + 1;
                if (residue_queue.size() == 0)
                begin
                    $error("result: expected none, got %0d", rsp.result);
                    mismatches++;
                end
                else if (rsp.result !== residue_queue[0])
                begin
                    $error("result: expected %0d, got %0d", residue_queue[0], rsp.result);
                    mismatches++;
                    void'(residue_queue.pop_front());
                end
                else
                    void'(residue_queue.pop_front());
            end
            rsp.ready <= (hold_left == 0) &&
                         ((results_seen >= STEADY_LO && results_seen < STEADY_HI) ||
                          $urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // one long receiver hold-off so the unit backs up into its input
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left  <= 0;
            hold_taken <= 1'b0;
        end
        else if (!hold_taken && results_seen == HOLD_AT)
        begin
            hold_left  <= HOLD_CYCLES;
            hold_taken <= 1'b1;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("prime_modular_arithmetic_unit: mismatch");
            $finish;
        end
    end

    initial
    begin
        bit [63:0] m;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        req.valid     = 1'b0;
        req.cmd       = '0;
        req.operand_a = '0;
        req.operand_b = '0;
        req.exponent  = '0;
        req.raw_value = '0;
        rsp.ready     = 1'b0;
        items_sent    = 0;
        mismatches    = 0;
        cycles        = 0;
        modulus_now   = pmau_pkg::MOD_RESET;
        m             = 64'(pmau_pkg::MOD_RESET);
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // directed items on the reset modulus
        push_op(pmau_pkg::CMD_ADD, 64'd0, 64'd0, 64'd0, 64'd0);
        push_op(pmau_pkg::CMD_ADD, m - 64'd1, m - 64'd1, 64'd0, 64'd0);
        push_op(pmau_pkg::CMD_ADD, OPERAND_MAX, OPERAND_MAX, 64'd0, 64'd0);
        push_op(pmau_pkg::CMD_SUB, 64'd0, 64'd1, 64'd0, 64'd0);
        push_op(pmau_pkg::CMD_SUB, m - 64'd1, 64'd0, 64'd0, 64'd0);
        push_op(pmau_pkg::CMD_SUB, 64'd5, OPERAND_MAX, 64'd0, 64'd0);
        push_op(pmau_pkg::CMD_MUL, m - 64'd1, m - 64'd1, 64'd0, 64'd0);
        push_op(pmau_pkg::CMD_MUL, OPERAND_MAX, 64'd12345, 64'd0, 64'd0);
        push_op(pmau_pkg::CMD_MUL, 64'd0, OPERAND_MAX, 64'd0, 64'd0);
        // zero to the power zero is one
        push_op(pmau_pkg::CMD_POW, 64'd0, 64'd0, 64'd0, 64'd0);
        push_op(pmau_pkg::CMD_POW, 64'd2, 64'd0, 64'd10, 64'd0);
        push_op(pmau_pkg::CMD_POW, m - 64'd1, 64'd0, ALL_EXP, 64'd0);
        push_op(pmau_pkg::CMD_POW, m + 64'd5, 64'd0, 64'h4000_0000_0000_0001, 64'd0);
        push_op(pmau_pkg::CMD_INV, 64'd0, 64'd0, 64'd0, 64'd0);
        push_op(pmau_pkg::CMD_INV, 64'd1, 64'd0, 64'd0, 64'd0);
        push_op(pmau_pkg::CMD_INV, m - 64'd1, 64'd0, 64'd0, 64'd0);
        push_op(pmau_pkg::CMD_INV, OPERAND_MAX, 64'd0, 64'd0, 64'd0);
        push_op(pmau_pkg::CMD_DIV, 64'd77, 64'd0, 64'd0, 64'd0);
        push_op(pmau_pkg::CMD_DIV, 64'd6, 64'd3, 64'd0, 64'd0);
        push_op(pmau_pkg::CMD_DIV, OPERAND_MAX, m + 64'd2, 64'd0, 64'd0);
        push_op(pmau_pkg::CMD_REDUCE, 64'd0, 64'd0, 64'd0, 64'd0);
        push_op(pmau_pkg::CMD_REDUCE, 64'd0, 64'd0, 64'd0, ALL_EXP);
        push_op(pmau_pkg::CMD_REDUCE, 64'd0, 64'd0, 64'd0, m);
        push_op(pmau_pkg::CMD_REDUCE, 64'd0, 64'd0, 64'd0, m - 64'd1);
        push_op(CMD_UNUSED, OPERAND_MAX, OPERAND_MAX, ALL_EXP, ALL_EXP);
        run_random(420);

        write_modulus(31'h7FFF_FFFF);
        run_random(250);
        write_modulus(31'd2);
        run_random(120);
        // modulus below two forces every result to zero
        write_modulus(31'd0);
        run_random(25);
        write_modulus(31'd1);
        run_random(25);
        write_modulus(M_W'($urandom_range(2, 32'h7FFF_FFFF)));
        run_random(250);
        write_modulus(M_W'($urandom_range(3, 1000)));
        run_random(200);
        write_modulus(31'd998244353);
        run_random(200);
        write_modulus(pmau_pkg::MOD_RESET);
        run_random(180);

        // let any stray result show up
        repeat (200) @(posedge clk);
        if (mismatches == 0)
            $display("prime_modular_arithmetic_unit: match");
        else
            $display("prime_modular_arithmetic_unit: mismatch");
        $finish;
    end

endmodule

[files.f]
src/pmau_pkg.sv
src/pmau_if.sv
src/pmau_datapath.sv
src/pmau_ctrl.sv
src/prime_modular_arithmetic_unit.sv
bench/tb_prime_modular_arithmetic_unit.sv
